// ===== design/s256h_pkg.sv =====
// s256h_pkg: shared types, constants and SHA-256 functions for the stream hasher.
// Used by s256h_msg, s256h_round and sha256_stream_hasher. No dependencies.
`default_nettype none

package s256h_pkg;

    // Eight 32-bit words; element 0 is a (or H0)
    typedef logic [7:0][31:0] t_words8;

    // Control from the sequencer to the message window
    typedef struct packed {
        logic       load_data;   // shift one message byte in
        logic [7:0] data;        // byte to shift in
        logic       shift_word;  // round step: drop oldest word, append new one
    } t_msg_ctl;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;   // first byte of the bit length
    localparam logic [5:0] LAST_POS = 6'd63;   // last byte of a block
    localparam logic [5:0] LAST_RND = 6'd63;
    localparam logic [2:0] LAST_IDX = 3'd7;

    localparam t_words8 H_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

// ===== design/s256h_msg.sv =====
// s256h_msg: 512-bit message window. Gathers bytes into a block, then acts as
// the 16-word schedule shift line during rounds. Depends on s256h_pkg.
`default_nettype none

module s256h_msg (
    input  wire logic                i_clk,
    input  wire s256h_pkg::t_msg_ctl i_ctl,
    input  wire logic [31:0]         i_new_word,
    output logic [31:0]              o_w0,
    output logic [31:0]              o_w1,
    output logic [31:0]              o_w9,
    output logic [31:0]              o_w14
);

    // word j of the window sits at bits [511-32j -: 32]; word 0 is w[t]
    logic [511:0] r_win;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_word) begin
            r_win <= {r_win[479:0], i_new_word};
        end else if (i_ctl.load_data) begin
            r_win <= {r_win[503:0], i_ctl.data};
        end
    end

    // fixed taps for round t: w[t], w[t+1], w[t+9], w[t+14]
    assign o_w0  = r_win[511:480];
    assign o_w1  = r_win[479:448];
    assign o_w9  = r_win[223:192];
    assign o_w14 = r_win[63:32];

endmodule

`default_nettype wire

// ===== design/s256h_round.sv =====
// s256h_round: the shared SHA-256 round unit, one round per use, plus the
// schedule word expansion. Pure logic. Depends on s256h_pkg.
`default_nettype none

module s256h_round (
    input  wire s256h_pkg::t_words8 i_work,
    input  wire logic [31:0]        i_k,
    input  wire logic [31:0]        i_w0,
    input  wire logic [31:0]        i_w1,
    input  wire logic [31:0]        i_w9,
    input  wire logic [31:0]        i_w14,
    output s256h_pkg::t_words8      o_work,
    output logic [31:0]             o_new_word
);

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    // round function on a..h
    always_comb begin
        ch  = (i_work[4] & i_work[5]) ^ (~i_work[4] & i_work[6]);
        maj = (i_work[0] & i_work[1]) ^ (i_work[0] & i_work[2]) ^ (i_work[1] & i_work[2]);
        t1  = i_work[7] + s256h_pkg::big_sigma1(i_work[4]) + ch + i_k + i_w0;
        t2  = s256h_pkg::big_sigma0(i_work[0]) + maj;
        o_work[0] = t1 + t2;
        o_work[1] = i_work[0];
        o_work[2] = i_work[1];
        o_work[3] = i_work[2];
        o_work[4] = i_work[3] + t1;
        o_work[5] = i_work[4];
        o_work[6] = i_work[5];
        o_work[7] = i_work[6];
    end

    // w[t+16] from the window taps
    assign o_new_word = s256h_pkg::small_sigma1(i_w14) + i_w9
                      + s256h_pkg::small_sigma0(i_w1) + i_w0;

endmodule

`default_nettype wire

// ===== design/sha256_stream_hasher.sv =====
// sha256_stream_hasher: byte-serial SHA-256 with padding and digest output.
// Depends on s256h_pkg, s256h_msg and s256h_round.
//
//   channel | handshake                  | word
//   --------+----------------------------+----------------------------------------
//   in      | i_in_valid / o_in_stall    | i_data_byte, i_has_byte, i_is_last
//   out     | o_out_valid / i_out_stall  | o_digest_word, o_word_index, o_final_word
//
// A byte word is absorbed into the message window; the byte that completes a block
// then runs the rounds of the shared round unit and the hash update.
// An end word pads one byte per cycle up to the block end (and a second block
// when the mark lands past byte 55), each block then runs the rounds and the hash
// update, and the eight digest words leave at one per cycle unless stalled.
// o_in_stall is high whenever the sequencer is not idle.
// Synchronous active-low reset returns to the initial hash values, empty message.
`default_nettype none

module sha256_stream_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_is_last,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_final_word
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_state;

    t_state               r_state;
    s256h_pkg::t_words8   r_hash;
    s256h_pkg::t_words8   r_work;
    s256h_pkg::t_words8   n_work;
    logic [5:0]           r_fill;
    logic [60:0]          r_total;
    logic [5:0]           r_round;
    logic [2:0]           r_widx;
    logic                 r_last;     // message end seen, finishing
    logic                 r_mark;     // 0x80 already appended
    logic                 r_len_ok;   // current block carries the bit length

    s256h_pkg::t_msg_ctl  msg_ctl;
    logic [31:0]          w0, w1, w9, w14, new_word;
    logic                 in_acc, out_acc;
    logic [63:0]          len_shift;

    assign in_acc  = i_in_valid && (r_state == ST_IDLE);
    assign out_acc = (r_state == ST_EMIT) && !i_out_stall;

    // byte source: input byte, pad mark, zero or length byte
    always_comb begin
        len_shift          = {r_total, 3'b000} << {r_fill[2:0], 3'b000};
        msg_ctl.load_data  = 1'b0;
        msg_ctl.data       = i_data_byte;
        msg_ctl.shift_word = (r_state == ST_ROUND);
        if (in_acc && i_has_byte) begin
            msg_ctl.load_data = 1'b1;
        end
        if (r_state == ST_PAD) begin
            msg_ctl.load_data = 1'b1;
            if (!r_mark) begin
                msg_ctl.data = s256h_pkg::PAD_MARK;
            end else if (r_len_ok && (r_fill >= s256h_pkg::LEN_POS)) begin
                msg_ctl.data = len_shift[63:56];
            end else begin
                msg_ctl.data = 8'h00;
            end
        end
    end

    s256h_msg u_msg (
        .i_clk      (i_clk),
        .i_ctl      (msg_ctl),
        .i_new_word (new_word),
        .o_w0       (w0),
        .o_w1       (w1),
        .o_w9       (w9),
        .o_w14      (w14)
    );

    s256h_round u_round (
        .i_work     (r_work),
        .i_k        (s256h_pkg::ROUND_K[r_round]),
        .i_w0       (w0),
        .i_w1       (w1),
        .i_w9       (w9),
        .i_w14      (w14),
        .o_work     (n_work),
        .o_new_word (new_word)
    );

    // sequencer, hash state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_hash   <= s256h_pkg::H_INIT;
            r_fill   <= '0;
            r_total  <= '0;
            r_round  <= '0;
            r_widx   <= '0;
            r_last   <= 1'b0;
            r_mark   <= 1'b0;
            r_len_ok <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_has_byte) begin
                            r_fill  <= r_fill + 6'd1;
                            r_total <= r_total + 61'd1;
                        end
                        if (i_has_byte && (r_fill == s256h_pkg::LAST_POS)) begin
                            r_state <= ST_ROUND;
                            r_round <= '0;
                            r_work  <= r_hash;
                            r_last  <= i_is_last;
                        end else if (i_is_last) begin
                            r_state <= ST_PAD;
                            r_last  <= 1'b1;
                        end
                    end
                end
                ST_PAD: begin
                    r_fill <= r_fill + 6'd1;
                    if (!r_mark) begin
                        r_mark   <= 1'b1;
                        r_len_ok <= (r_fill < s256h_pkg::LEN_POS);
                    end
                    if (r_fill == s256h_pkg::LAST_POS) begin
                        r_state <= ST_ROUND;
                        r_round <= '0;
                        r_work  <= r_hash;
                    end
                end
                ST_ROUND: begin
                    r_work  <= n_work;
                    r_round <= r_round + 6'd1;
                    if (r_round == s256h_pkg::LAST_RND) begin
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    for (int j = 0; j < 8; j++) begin
                        r_hash[j] <= r_hash[j] + r_work[j];
                    end
                    if (!r_last) begin
                        r_state <= ST_IDLE;
                    end else if (r_mark && r_len_ok) begin
                        r_state <= ST_EMIT;
                        r_widx  <= '0;
                    end else begin
                        // no mark yet, or mark past byte 55: mark and/or length go in a fresh block
                        r_state <= ST_PAD;
                        if (r_mark) begin
                            r_len_ok <= 1'b1;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_acc) begin
                        r_widx <= r_widx + 3'd1;
                        if (r_widx == s256h_pkg::LAST_IDX) begin
                            r_state  <= ST_IDLE;
                            r_hash   <= s256h_pkg::H_INIT;
                            r_total  <= '0;
                            r_last   <= 1'b0;
                            r_mark   <= 1'b0;
                            r_len_ok <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = (r_state == ST_EMIT);
    assign o_digest_word = r_hash[r_widx];
    assign o_word_index  = r_widx;
    assign o_final_word  = (r_widx == s256h_pkg::LAST_IDX);

endmodule

`default_nettype wire

// ===== design/s256h_checker.sv =====
// s256h_checker: port-level assertions for sha256_stream_hasher, bound to it.
// Depends only on the top level's ports.
`default_nettype none

module s256h_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [31:0] o_digest_word,
    input wire logic [2:0]  o_word_index,
    input wire logic        o_final_word
);

    // no input word is taken while the digest is going out
    a_stall_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted during digest output");

    // final flag only on the eighth word
    a_final_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_final_word == (o_word_index == 3'd7)))
        else $error("final_word does not match word_index");

    // digest words leave in order, with no gap
    a_next_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_final_word) |=>
        (o_out_valid && (o_word_index == 3'($past(o_word_index) + 3'd1))))
        else $error("digest word sequence broken");

    // digest ends after the final word
    a_end_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_final_word) |=> !o_out_valid)
        else $error("extra digest word after final");

    // stalled word holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_digest_word)))
        else $error("stalled digest word changed");

endmodule

bind sha256_stream_hasher s256h_checker u_s256h_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_final_word  (o_final_word)
);

`default_nettype wire

// ===== sim/sha256_digest_check.sv =====
// sha256_digest_check: watches both channels of sha256_stream_hasher, predicts the
// digest words from the accepted input words and compares them in arrival order.
// Stand-alone; the SHA-256 prediction is written here and uses nothing from the RTL.
module sha256_digest_check (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_is_last,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [31:0] i_digest_word,
    input  wire logic [2:0]  i_word_index,
    input  wire logic        i_final_word,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_entry;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // predicted hasher state
    logic [31:0]   chain_h [8];
    logic [7:0]    msg_block [64];
    int            block_fill;
    logic [60:0]   msg_bytes;
    t_digest_entry digest_due [$];
    int            fails;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // 64 rounds over the gathered block, folded into the chaining value
    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wt, t1, t2, s0, s1;
        for (int j = 0; j < 16; j++)
            w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
        for (int j = 0; j < 8; j++)
            v[j] = chain_h[j];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                wt = w[r];
            end else begin
                s1 = ror(w[(r-2)&15], 17) ^ ror(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10);
                s0 = ror(w[(r-15)&15], 7) ^ ror(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3);
                wt = s1 + w[(r-7)&15] + s0 + w[r&15];
                w[r&15] = wt;
            end
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + wt;
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++)
            chain_h[j] = chain_h[j] + v[j];
    endfunction

    function automatic void restart_message();
        chain_h    = SHA_H0;
        block_fill = 0;
        msg_bytes  = '0;
    endfunction

    // one accepted input word: absorb the byte, then pad and finish on the end flag
    function automatic void absorb_word(input logic [7:0] data, input logic has,
                                        input logic last);
        logic [63:0]   bit_len;
        t_digest_entry entry;
        if (has) begin
            msg_block[block_fill] = data;
            block_fill++;
            msg_bytes = msg_bytes + 1'b1;
            if (block_fill == 64) begin
                compress_block();
                block_fill = 0;
            end
        end
        if (last) begin
            msg_block[block_fill] = 8'h80;
            block_fill++;
            // mark past the length field: flush an extra block
            if (block_fill > 56) begin
                for (int j = block_fill; j < 64; j++)
                    msg_block[j] = 8'h00;
                compress_block();
                block_fill = 0;
            end
            for (int j = block_fill; j < 56; j++)
                msg_block[j] = 8'h00;
            bit_len = {msg_bytes, 3'b000};
            for (int j = 0; j < 8; j++)
                msg_block[56 + j] = bit_len[63 - 8*j -: 8];
            compress_block();
            for (int j = 0; j < 8; j++) begin
                entry.word = chain_h[j];
                entry.idx  = 3'(j);
                entry.last = (j == 7);
                digest_due.push_back(entry);
            end
            restart_message();
        end
    endfunction

    task automatic report_mismatch(input string what);
        fails++;
        $display("%0t: digest check: %s", $time, what);
    endtask

    // compare digest words first, then fold in the accepted input word
    always @(posedge i_clk) begin
        t_digest_entry due;
        if (!i_rst_n) begin
            restart_message();
            digest_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (digest_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %08h index %0d final %0b",
                                              i_digest_word, i_word_index, i_final_word));
                end else begin
                    due = digest_due.pop_front();
                    if (i_digest_word !== due.word)
                        report_mismatch($sformatf("digest_word %08h, want %08h (index %0d)",
                                                  i_digest_word, due.word, due.idx));
                    if (i_word_index !== due.idx)
                        report_mismatch($sformatf("word_index %0d, want %0d",
                                                  i_word_index, due.idx));
                    if (i_final_word !== due.last)
                        report_mismatch($sformatf("final_word %0b, want %0b (index %0d)",
                                                  i_final_word, due.last, due.idx));
                end
            end
            if (i_in_valid && !i_in_stall)
                absorb_word(i_data_byte, i_has_byte, i_is_last);
        end
        o_fail_count <= fails;
        o_pending    <= digest_due.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// tb_top: stimulus, output back-pressure, watchdog and verdict for sha256_stream_hasher.
// Depends on the RTL and on sha256_digest_check, which does the prediction and digest checking.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_WORDS = 420;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_has_byte;
    logic        i_is_last;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_final_word;

    int fail_count;
    int pending;
    int words_sent;
    int idle_cycles;
    bit burst_mode;
    bit hold_req;

    sha256_stream_hasher DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_has_byte    (i_has_byte),
        .i_is_last     (i_is_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_final_word  (o_final_word)
    );

    sha256_digest_check u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_has_byte    (i_has_byte),
        .i_is_last     (i_is_last),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_digest_word (o_digest_word),
        .i_word_index  (o_word_index),
        .i_final_word  (o_final_word),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // watchdog: cycles in which neither channel moves a word
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 50);
    endfunction

    // message lengths lean on the padding boundaries around 55/56 and 64, in the first and second block
    function automatic int pick_len();
        int r;
        int edges [10] = '{54, 55, 56, 57, 63, 64, 65, 119, 120, 128};
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(0, 12);
        if (r < 75)
            return edges[$urandom_range(0, 9)];
        return $urandom_range(13, 130);
    endfunction

    // offer one word and hold it until accepted; valid stays high for a back-to-back word
    task automatic send_word(input logic [7:0] data, input logic has, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= data;
        i_has_byte  <= has;
        i_is_last   <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (has || last)
            words_sent++;
    endtask

    // whole message, ended either on its last byte or by a separate end word
    task automatic send_message(input int len);
        bit end_on_byte;
        end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int n = 0; n < len; n++) begin
            if (!burst_mode && $urandom_range(0, 19) == 0)
                send_word(8'($urandom), 1'b0, 1'b0);
            send_word(8'($urandom), 1'b1, end_on_byte && (n == len - 1));
        end
        if (!end_on_byte)
            send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    // receiver: random stall runs, plus one long hold while the sender keeps going
    initial begin
        int n;
        bit v;
        i_out_stall = 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                n = $urandom_range(0, 99);
                v = (n >= 40);
                if (n < 40)
                    n = $urandom_range(1, 30);
                else if (n < 85)
                    n = $urandom_range(1, 3);
                else
                    n = $urandom_range(10, 60);
                i_out_stall <= v;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // stimulus and verdict
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_data_byte = 8'h00;
        i_has_byte  = 1'b0;
        i_is_last   = 1'b0;
        burst_mode  = 1'b0;
        hold_req    = 1'b0;
        words_sent  = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty message, idle words, single extreme bytes, "abc" two ways
        send_word(8'h5a, 1'b0, 1'b1);
        send_word(8'hff, 1'b0, 1'b0);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hff, 1'b1, 1'b1);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b0);
        send_word(8'hff, 1'b0, 1'b1);
        send_word(8'h00, 1'b0, 1'b1);

        // random messages; the receiver takes its long hold early on
        hold_req   = 1'b1;
        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            burst_mode = ($urandom_range(0, 3) == 0);
            send_message(pick_len());
        end
        i_in_valid <= 1'b0;

        // drain the remaining digest words, then let the block settle
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
